FILE: design/cfpg_pkg.sv
// Shared types, register indexes and helpers for the color keyed floor point generator.
package cfpg_pkg;

    localparam int unsigned COLOR_W = 8;
    localparam int unsigned INDEX_W = 12;
    localparam int unsigned COEF_W  = 31;
    localparam int unsigned COORD_W = 32;
    localparam int unsigned WIN_W   = 48;
    localparam int unsigned CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_ONE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_TWO  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_H      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_W      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_H       = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_W       = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_LIFT_HEIGHT = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_LIFT_STEP   = 3'd7;

    localparam logic [COEF_W-1:0] LIFT_HEIGHT_RESET = 31'd1048576;

    typedef struct packed {
        logic [COLOR_W-1:0] red;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] blue;
        logic [INDEX_W-1:0] pixel_row;
        logic [INDEX_W-1:0] pixel_col;
    } t_pixel;

    typedef struct packed {
        logic signed [COORD_W-1:0] point_x;
        logic signed [COORD_W-1:0] point_y;
        logic signed [COORD_W-1:0] point_z;
        logic [3*COLOR_W-1:0]      packed_color;
        logic                      is_lifted;
        logic                      last_of_run;
    } t_point;

    // Inclusive box test; an empty range simply never matches.
    function automatic logic in_window(input logic [WIN_W-1:0] win,
                                       input logic [COLOR_W-1:0] r,
                                       input logic [COLOR_W-1:0] g,
                                       input logic [COLOR_W-1:0] b);
        logic ok;
        ok = (r >= win[7:0])   && (r <= win[31:24]) &&
             (g >= win[15:8])  && (g <= win[39:32]) &&
             (b >= win[23:16]) && (b <= win[47:40]);
        return ok;
    endfunction

endpackage

FILE: design/cfpg_coord.sv
// One floor axis: registered index times step, then base minus product with saturation.
module cfpg_coord (
    input  logic                                i_clk,
    input  logic                                i_mul_en,
    input  logic                                i_sub_en,
    input  logic [cfpg_pkg::INDEX_W-1:0]        i_index,
    input  logic [cfpg_pkg::COEF_W-1:0]         i_step,
    input  logic [cfpg_pkg::COEF_W-1:0]         i_base,
    output logic signed [cfpg_pkg::COORD_W-1:0] o_coord
);
    import cfpg_pkg::*;

    localparam int unsigned PROD_W = INDEX_W + COEF_W;
    localparam int unsigned DIFF_W = PROD_W + 2;

    logic [PROD_W-1:0]         r_prod;
    logic signed [DIFF_W-1:0]  diff;
    logic signed [COORD_W-1:0] n_coord;
    logic signed [COORD_W-1:0] r_coord;

    always_ff @(posedge i_clk) begin
        if (i_mul_en) begin
            r_prod <= PROD_W'(i_index) * PROD_W'(i_step);
        end
        if (i_sub_en) begin
            r_coord <= n_coord;
        end
    end

    // The base is below 2^31, so only the negative side can overflow.
    always_comb begin
        diff = $signed(DIFF_W'(i_base)) - $signed(DIFF_W'(r_prod));
        if (diff < -$signed(DIFF_W'(64'h8000_0000))) begin
            n_coord = {1'b1, {(COORD_W-1){1'b0}}};
        end else begin
            n_coord = diff[COORD_W-1:0];
        end
    end

    assign o_coord = r_coord;

endmodule

FILE: design/color_keyed_floor_point_generator.sv
// Top level of the color keyed floor point generator: pixel pipeline and point sequencer.
//
// Each accepted pixel beat is placed on the floor plane at x = max_h - row*step_h and
// y = max_w - col*step_w (signed Q12.20, saturated to 32 bits) and its color is tested
// against two inclusive RGB boxes. A pixel outside both boxes yields one point at z = 0;
// a pixel inside either box yields a lifted column at z = 0, lift_step, 2*lift_step, ...
// up to and including lift_height, capped at MAX_LIFT_POINTS points. Pixels flow through
// three register stages (window test and index clamp, multiply, subtract and saturate)
// into an output register that doubles as the column sequencer, so the input takes one
// pixel per cycle while points are unlifted and the output is not stalled; a lifted
// column occupies the output register until its last point is taken and holds the
// pipeline behind it. Configuration registers are plain writes and should only change
// while no pixel is in flight.
module color_keyed_floor_point_generator #(
    parameter int unsigned MAX_LIFT_POINTS = 64,
    parameter int unsigned MAX_IMAGE_DIM   = 4096
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  cfpg_pkg::t_pixel               i_in_pixel,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output cfpg_pkg::t_point               o_out_point,
    input  logic                           i_cfg_we,
    input  logic [cfpg_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [cfpg_pkg::WIN_W-1:0]     i_cfg_data
);
    import cfpg_pkg::*;

    localparam int unsigned CNT_W = (MAX_LIFT_POINTS > 1) ? $clog2(MAX_LIFT_POINTS) : 1;
    localparam int unsigned IDX_LIMIT = (MAX_IMAGE_DIM - 1 < (1 << INDEX_W) - 1) ?
                                        MAX_IMAGE_DIM - 1 : (1 << INDEX_W) - 1;
    localparam logic [INDEX_W-1:0] IDX_MAX = INDEX_W'(IDX_LIMIT);

    // Configuration registers.
    logic [WIN_W-1:0]  r_window_one;
    logic [WIN_W-1:0]  r_window_two;
    logic [COEF_W-1:0] r_step_h;
    logic [COEF_W-1:0] r_step_w;
    logic [COEF_W-1:0] r_max_h;
    logic [COEF_W-1:0] r_max_w;
    logic [COEF_W-1:0] r_lift_height;
    logic [COEF_W-1:0] r_lift_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_one  <= '0;
            r_window_two  <= '0;
            r_step_h      <= '0;
            r_step_w      <= '0;
            r_max_h       <= '0;
            r_max_w       <= '0;
            r_lift_height <= LIFT_HEIGHT_RESET;
            r_lift_step   <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_WINDOW_ONE:  r_window_one  <= i_cfg_data;
                REG_WINDOW_TWO:  r_window_two  <= i_cfg_data;
                REG_STEP_H:      r_step_h      <= i_cfg_data[COEF_W-1:0];
                REG_STEP_W:      r_step_w      <= i_cfg_data[COEF_W-1:0];
                REG_MAX_H:       r_max_h       <= i_cfg_data[COEF_W-1:0];
                REG_MAX_W:       r_max_w       <= i_cfg_data[COEF_W-1:0];
                REG_LIFT_HEIGHT: r_lift_height <= i_cfg_data[COEF_W-1:0];
                REG_LIFT_STEP:   r_lift_step   <= i_cfg_data[COEF_W-1:0];
                default: ;
            endcase
        end
    end

    // Pipeline flow control. The output register frees up when it is empty or its
    // last point of the current run is being taken; every stage behind it moves when
    // the stage ahead is free, so a stall never drops or repeats a beat.
    logic r_s1_valid, r_s2_valid, r_s3_valid, r_o_valid;
    logic r_o_last;
    logic out_free, s3_free, s2_free, s1_free;
    logic out_step;

    assign out_free = !r_o_valid || (i_out_ready && r_o_last);
    assign out_step = r_o_valid && i_out_ready && !r_o_last;
    assign s3_free  = !r_s3_valid || out_free;
    assign s2_free  = !r_s2_valid || s3_free;
    assign s1_free  = !r_s1_valid || s2_free;
    assign o_in_ready = s1_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            if (s1_free) r_s1_valid <= i_in_valid;
            if (s2_free) r_s2_valid <= r_s1_valid;
            if (s3_free) r_s3_valid <= r_s2_valid;
            if (out_free) r_o_valid <= r_s3_valid;
        end
    end

    // Stage 1: index clamp and window test.
    logic [INDEX_W-1:0]   r_s1_row, r_s1_col;
    logic [3*COLOR_W-1:0] r_s1_color;
    logic                 r_s1_lift;
    logic [3*COLOR_W-1:0] r_s2_color, r_s3_color;
    logic                 r_s2_lift, r_s3_lift;

    always_ff @(posedge i_clk) begin
        if (s1_free) begin
            r_s1_row   <= (i_in_pixel.pixel_row > IDX_MAX) ? IDX_MAX : i_in_pixel.pixel_row;
            r_s1_col   <= (i_in_pixel.pixel_col > IDX_MAX) ? IDX_MAX : i_in_pixel.pixel_col;
            r_s1_color <= {i_in_pixel.red, i_in_pixel.green, i_in_pixel.blue};
            r_s1_lift  <= in_window(r_window_one, i_in_pixel.red, i_in_pixel.green,
                                    i_in_pixel.blue) ||
                          in_window(r_window_two, i_in_pixel.red, i_in_pixel.green,
                                    i_in_pixel.blue);
        end
        if (s2_free) begin
            r_s2_color <= r_s1_color;
            r_s2_lift  <= r_s1_lift;
        end
        if (s3_free) begin
            r_s3_color <= r_s2_color;
            r_s3_lift  <= r_s2_lift;
        end
    end

    // Stages 2 and 3: multiply, then subtract and saturate, one unit per axis.
    logic signed [COORD_W-1:0] s3_x, s3_y;

    cfpg_coord u_coord_x (
        .i_clk    (i_clk),
        .i_mul_en (s2_free),
        .i_sub_en (s3_free),
        .i_index  (r_s1_row),
        .i_step   (r_step_h),
        .i_base   (r_max_h),
        .o_coord  (s3_x)
    );

    cfpg_coord u_coord_y (
        .i_clk    (i_clk),
        .i_mul_en (s2_free),
        .i_sub_en (s3_free),
        .i_index  (r_s1_col),
        .i_step   (r_step_w),
        .i_base   (r_max_w),
        .o_coord  (s3_y)
    );

    // Output register and column sequencer. r_o_z_next holds the z of the following
    // point so that the end-of-column test is one add and one compare per cycle.
    logic signed [COORD_W-1:0] r_o_x, r_o_y;
    logic [COORD_W-1:0]        r_o_z, r_o_z_next;
    logic [3*COLOR_W-1:0]      r_o_color;
    logic                      r_o_lift;
    logic [CNT_W-1:0]          r_o_cnt;
    logic [COORD_W-1:0]        z_after;
    logic                      first_last;
    logic                      next_last;

    assign z_after    = r_o_z_next + COORD_W'(r_lift_step);
    assign first_last = !r_s3_lift || (MAX_LIFT_POINTS == 1) || (r_lift_step > r_lift_height);
    assign next_last  = ((CNT_W + 1)'(r_o_cnt) + (CNT_W + 1)'(1) ==
                         (CNT_W + 1)'(MAX_LIFT_POINTS - 1)) ||
                        (z_after > COORD_W'(r_lift_height));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_last <= 1'b0;
        end else if (out_free) begin
            r_o_last <= first_last;
        end else if (out_step) begin
            r_o_last <= next_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            r_o_x      <= s3_x;
            r_o_y      <= s3_y;
            r_o_z      <= '0;
            r_o_z_next <= COORD_W'(r_lift_step);
            r_o_color  <= r_s3_color;
            r_o_lift   <= r_s3_lift;
            r_o_cnt    <= '0;
        end else if (out_step) begin
            r_o_z      <= r_o_z_next;
            r_o_z_next <= z_after;
            r_o_cnt    <= r_o_cnt + CNT_W'(1);
        end
    end

    assign o_out_valid              = r_o_valid;
    assign o_out_point.point_x      = r_o_x;
    assign o_out_point.point_y      = r_o_y;
    assign o_out_point.point_z      = $signed(r_o_z);
    assign o_out_point.packed_color = r_o_color;
    assign o_out_point.is_lifted    = r_o_lift;
    assign o_out_point.last_of_run  = r_o_last;

    // A point outside both windows always closes its run.
    a_unlifted_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && !r_o_lift) |-> r_o_last)
        else $error("unlifted point not marked last");

    // A lifted point never rises above the configured column height.
    a_z_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && r_o_lift) |-> (r_o_z <= COORD_W'(r_lift_height)))
        else $error("lifted point above lift height");

    // The column counter stays below the point cap.
    a_cnt_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_valid |-> ((CNT_W + 1)'(r_o_cnt) < (CNT_W + 1)'(MAX_LIFT_POINTS)))
        else $error("column exceeds point cap");

    // Taking a non-final point advances z by one step within the same run.
    a_z_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_step |=> (r_o_valid && r_o_lift &&
                      r_o_z == $past(r_o_z) + COORD_W'(r_lift_step)))
        else $error("column z did not advance by one step");

endmodule

FILE: test/tb_color_keyed_floor_point_generator.sv
// Testbench for the color keyed floor point generator: directed table, random phases.
module tb_color_keyed_floor_point_generator;
    import cfpg_pkg::*;

    localparam int CLK_PERIOD    = 12;
    localparam int LIFT_CAP      = 64;
    localparam int IMAGE_DIM     = 4096;
    localparam int HOLD_LEN      = 150;
    localparam int TAIL_CYCLES   = 16;
    localparam int RANDOM_PHASES = 6;
    localparam int PHASE_PIXELS  = 35;
    localparam int LIMIT_CYCLES  = 600000;

    typedef struct packed {
        logic [WIN_W-1:0]  win_one;
        logic [WIN_W-1:0]  win_two;
        logic [COEF_W-1:0] step_h;
        logic [COEF_W-1:0] step_w;
        logic [COEF_W-1:0] max_h;
        logic [COEF_W-1:0] max_w;
        logic [COEF_W-1:0] lift_height;
        logic [COEF_W-1:0] lift_step;
    } t_floor_cfg;

    // One row of the directed table; typed rows carry their single point written out.
    typedef struct packed {
        logic [2:0] cfg_set;
        t_pixel     pix;
        logic       typed;
        t_point     want;
    } t_probe;

    logic clk = 1'b0;
    logic rst_n;
    logic pix_valid;
    logic pix_ready;
    t_pixel pix;
    logic pt_valid;
    logic pt_ready = 1'b0;
    t_point pt_data;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [WIN_W-1:0] cfg_data;

    t_floor_cfg cfg;
    t_floor_cfg directed_cfg [5];
    t_probe probes [$];
    t_point floor_points_due [$];
    int point_errors = 0;
    bit tx_may_idle = 1'b1;
    bit rx_may_idle = 1'b1;
    bit hold_request = 1'b0;
    int hold_cycles = 0;

    color_keyed_floor_point_generator #(
        .MAX_LIFT_POINTS(LIFT_CAP),
        .MAX_IMAGE_DIM(IMAGE_DIM)
    ) dut (
        .i_clk(clk),
        .i_rst_n(rst_n),
        .i_in_valid(pix_valid),
        .o_in_ready(pix_ready),
        .i_in_pixel(pix),
        .o_out_valid(pt_valid),
        .i_out_ready(pt_ready),
        .o_out_point(pt_data),
        .i_cfg_we(cfg_we),
        .i_cfg_idx(cfg_idx),
        .i_cfg_data(cfg_data)
    );

    initial begin
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    function automatic logic [WIN_W-1:0] make_box(input logic [7:0] rl, input logic [7:0] gl,
                                                  input logic [7:0] bl, input logic [7:0] rh,
                                                  input logic [7:0] gh, input logic [7:0] bh);
        return {bh, gh, rh, bl, gl, rl};
    endfunction

    function automatic bit color_in_box(input logic [WIN_W-1:0] box, input t_pixel p);
        return p.red >= box[7:0] && p.red <= box[31:24] &&
               p.green >= box[15:8] && p.green <= box[39:32] &&
               p.blue >= box[23:16] && p.blue <= box[47:40];
    endfunction

    // base - index*step, computed wide and saturated to the signed 32-bit range.
    function automatic logic [COORD_W-1:0] plane_coord(input logic [COEF_W-1:0] base,
                                                      input logic [COEF_W-1:0] step,
                                                      input logic [INDEX_W-1:0] index);
        longint idx;
        longint v;
        idx = longint'(index);
        if (idx > IMAGE_DIM - 1)
            idx = IMAGE_DIM - 1;
        v = longint'(base) - idx * longint'(step);
        if (v > 64'sd2147483647)
            return 32'h7FFF_FFFF;
        if (v < -64'sd2147483648)
            return 32'h8000_0000;
        return v[31:0];
    endfunction

    // Appends one point to the scoreboard queue.
    task automatic due_point(input t_point pt);
        floor_points_due = {floor_points_due, pt};
    endtask

    // Queues every point that one pixel produces under the current register settings.
    task automatic place_pixel_points(input t_pixel p);
        t_point pt;
        longint z;
        int n;
        pt.point_x = plane_coord(cfg.max_h, cfg.step_h, p.pixel_row);
        pt.point_y = plane_coord(cfg.max_w, cfg.step_w, p.pixel_col);
        pt.packed_color = {p.red, p.green, p.blue};
        if (!(color_in_box(cfg.win_one, p) || color_in_box(cfg.win_two, p))) begin
            pt.point_z = '0;
            pt.is_lifted = 1'b0;
            pt.last_of_run = 1'b1;
            due_point(pt);
        end else begin
            z = 0;
            n = 0;
            pt.is_lifted = 1'b1;
            while (n < LIFT_CAP && z <= longint'(cfg.lift_height)) begin
                pt.point_z = z[31:0];
                n++;
                z += longint'(cfg.lift_step);
                pt.last_of_run = (n == LIFT_CAP) || (z > longint'(cfg.lift_height));
                due_point(pt);
            end
        end
    endtask

    function automatic t_pixel px(input int r, input int g, input int b, input int row,
                                  input int col);
        t_pixel p;
        p.red = COLOR_W'(r);
        p.green = COLOR_W'(g);
        p.blue = COLOR_W'(b);
        p.pixel_row = INDEX_W'(row);
        p.pixel_col = INDEX_W'(col);
        return p;
    endfunction

    function automatic t_point pt_flat(input logic [31:0] x, input logic [31:0] y,
                                       input logic [31:0] z, input logic [23:0] color,
                                       input logic lifted, input logic last);
        t_point pt;
        pt.point_x = x;
        pt.point_y = y;
        pt.point_z = z;
        pt.packed_color = color;
        pt.is_lifted = lifted;
        pt.last_of_run = last;
        return pt;
    endfunction

    task automatic add_probe(input int set, input t_pixel p, input bit typed, input t_point want);
        t_probe row;
        row.cfg_set = 3'(set);
        row.pix = p;
        row.typed = typed;
        row.want = want;
        probes = {probes, row};
    endtask

    function automatic logic [WIN_W-1:0] random_box();
        logic [7:0] lo [3];
        logic [7:0] hi [3];
        if ($urandom_range(0, 5) == 0)
            return WIN_W'({$urandom, $urandom});
        for (int c = 0; c < 3; c++) begin
            lo[c] = 8'($urandom_range(0, 255));
            hi[c] = 8'($urandom_range(lo[c], 255));
        end
        return make_box(lo[0], lo[1], lo[2], hi[0], hi[1], hi[2]);
    endfunction

    function automatic logic [COEF_W-1:0] random_step();
        if ($urandom_range(0, 3) == 0)
            return COEF_W'($urandom);
        return COEF_W'($urandom_range(0, 1 << 21));
    endfunction

    function automatic t_floor_cfg random_cfg();
        t_floor_cfg c;
        c.win_one = random_box();
        c.win_two = random_box();
        c.step_h = random_step();
        c.step_w = random_step();
        c.max_h = COEF_W'($urandom);
        c.max_w = COEF_W'($urandom);
        case ($urandom_range(0, 7))
            0: begin
                c.lift_step = '0;
                c.lift_height = COEF_W'($urandom);
            end
            1: begin
                c.lift_step = COEF_W'($urandom_range(1, 64));
                c.lift_height = '1;
            end
            default: begin
                c.lift_step = COEF_W'($urandom_range(1, 1 << 24));
                c.lift_height = COEF_W'(c.lift_step * $urandom_range(0, 7) +
                                        $urandom_range(0, c.lift_step - 1));
            end
        endcase
        return c;
    endfunction

    // Half the pixels are aimed inside one of the boxes so lifted columns stay common.
    function automatic t_pixel random_pixel();
        t_pixel p;
        logic [WIN_W-1:0] box;
        int sel;
        sel = $urandom_range(0, 3);
        box = sel[0] ? cfg.win_one : cfg.win_two;
        if (sel < 2) begin
            p.red = COLOR_W'($urandom_range(box[7:0], box[31:24]));
            p.green = COLOR_W'($urandom_range(box[15:8], box[39:32]));
            p.blue = COLOR_W'($urandom_range(box[23:16], box[47:40]));
        end else begin
            {p.red, p.green, p.blue} = 24'($urandom);
        end
        p.pixel_row = INDEX_W'($urandom);
        p.pixel_col = INDEX_W'($urandom);
        if ($urandom_range(0, 7) == 0)
            p.pixel_row = $urandom_range(0, 1) ? '1 : '0;
        if ($urandom_range(0, 7) == 0)
            p.pixel_col = $urandom_range(0, 1) ? '1 : '0;
        return p;
    endfunction

    // Entered and left at a falling edge.
    task automatic send_pixel(input t_pixel p, input bit typed, input t_point want);
        while (tx_may_idle && $urandom_range(0, 99) < 22) begin
            pix_valid <= 1'b0;
            @(negedge clk);
        end
        pix_valid <= 1'b1;
        pix <= p;
        @(posedge clk);
        while (!pix_ready)
            @(posedge clk);
        if (typed)
            due_point(want);
        else
            place_pixel_points(p);
        @(negedge clk);
    endtask

    task automatic wait_points_drained();
        pix_valid <= 1'b0;
        while (floor_points_due.size() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [WIN_W-1:0] data);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= data;
        @(negedge clk);
    endtask

    task automatic apply_cfg(input t_floor_cfg c);
        write_reg(REG_WINDOW_ONE, c.win_one);
        write_reg(REG_WINDOW_TWO, c.win_two);
        write_reg(REG_STEP_H, WIN_W'(c.step_h));
        write_reg(REG_STEP_W, WIN_W'(c.step_w));
        write_reg(REG_MAX_H, WIN_W'(c.max_h));
        write_reg(REG_MAX_W, WIN_W'(c.max_w));
        write_reg(REG_LIFT_HEIGHT, WIN_W'(c.lift_height));
        write_reg(REG_LIFT_STEP, WIN_W'(c.lift_step));
        cfg_we <= 1'b0;
        cfg = c;
    endtask

    task automatic take_point(input t_point got);
        t_point want;
        if (floor_points_due.size() == 0) begin
            if (point_errors < 10)
                $display("point with nothing due: x=%h y=%h z=%h color=%h lifted=%b last=%b",
                         got.point_x, got.point_y, got.point_z, got.packed_color,
                         got.is_lifted, got.last_of_run);
            point_errors++;
        end else begin
            want = floor_points_due.pop_front();
            if (got.point_x !== want.point_x || got.point_y !== want.point_y ||
                got.point_z !== want.point_z || got.packed_color !== want.packed_color ||
                got.is_lifted !== want.is_lifted || got.last_of_run !== want.last_of_run) begin
                if (point_errors < 10) begin
                    $display("point mismatch, expected x=%h y=%h z=%h color=%h lifted=%b last=%b",
                             want.point_x, want.point_y, want.point_z, want.packed_color,
                             want.is_lifted, want.last_of_run);
                    $display("                  got x=%h y=%h z=%h color=%h lifted=%b last=%b",
                             got.point_x, got.point_y, got.point_z, got.packed_color,
                             got.is_lifted, got.last_of_run);
                end
                point_errors++;
            end
        end
    endtask

    // Output side: random stalls, or a long hold-off when one is requested.
    always @(negedge clk) begin
        if (hold_cycles != 0) begin
            pt_ready <= 1'b0;
            hold_cycles <= hold_cycles - 1;
        end else if (hold_request) begin
            pt_ready <= 1'b0;
            hold_cycles <= HOLD_LEN - 1;
            hold_request = 1'b0;
        end else begin
            pt_ready <= rx_may_idle ? ($urandom_range(0, 99) >= 22) : 1'b1;
        end
    end

    always @(posedge clk) begin
        if (rst_n && pt_valid && pt_ready)
            take_point(pt_data);
    end

    initial begin
        #(LIMIT_CYCLES * CLK_PERIOD);
        $display("simulation failed");
        $finish;
    end

    initial begin
        int cur_set;
        rst_n = 1'b0;
        pix_valid = 1'b0;
        pix = '0;
        cfg_we = 1'b0;
        cfg_idx = '0;
        cfg_data = '0;
        cfg = '0;
        cfg.lift_height = LIFT_HEIGHT_RESET;

        // Set 1: steps and bases at their extremes, first box empty, second box everything,
        // so every pixel lifts into exactly two points.
        directed_cfg[1].win_one = make_box(255, 255, 255, 0, 0, 0);
        directed_cfg[1].win_two = make_box(0, 0, 0, 255, 255, 255);
        directed_cfg[1].step_h = '1;
        directed_cfg[1].step_w = '1;
        directed_cfg[1].max_h = '0;
        directed_cfg[1].max_w = '1;
        directed_cfg[1].lift_height = '1;
        directed_cfg[1].lift_step = '1;
        // Set 2: box edges, 1.0 and 0.5 pixel pitch, one-point columns.
        directed_cfg[2].win_one = make_box(10, 20, 30, 40, 50, 60);
        directed_cfg[2].win_two = make_box(200, 200, 200, 255, 255, 255);
        directed_cfg[2].step_h = 31'h0010_0000;
        directed_cfg[2].step_w = 31'h0008_0000;
        directed_cfg[2].max_h = 31'h0640_0000;
        directed_cfg[2].max_w = 31'h0320_0000;
        directed_cfg[2].lift_height = '0;
        directed_cfg[2].lift_step = 31'd5;
        // Set 3: lift_height an exact multiple of the step, so the top point is included.
        directed_cfg[3] = directed_cfg[2];
        directed_cfg[3].lift_step = 31'h0004_0000;
        directed_cfg[3].lift_height = 31'h0010_0000;
        // Set 4: tiny step under the tallest column, so the point cap cuts it off.
        directed_cfg[4] = directed_cfg[2];
        directed_cfg[4].step_h = '0;
        directed_cfg[4].step_w = '0;
        directed_cfg[4].max_h = '1;
        directed_cfg[4].max_w = '1;
        directed_cfg[4].lift_step = 31'd1;
        directed_cfg[4].lift_height = '1;

        // Set 0 is the reset state: both boxes hold only black, zero lift step.
        add_probe(0, px(255, 255, 255, 0, 0), 1, pt_flat(0, 0, 0, 24'hFFFFFF, 0, 1));
        add_probe(0, px(0, 0, 0, 4095, 4095), 0, '0);
        add_probe(0, px(1, 0, 0, 4095, 4095), 1, pt_flat(0, 0, 0, 24'h010000, 0, 1));
        add_probe(1, px(0, 0, 0, 0, 0), 0, '0);
        add_probe(1, px(255, 255, 255, 1, 1), 0, '0);
        add_probe(1, px(128, 64, 32, 4095, 4095), 0, '0);
        add_probe(1, px(255, 0, 255, 2, 0), 0, '0);
        add_probe(2, px(10, 20, 30, 0, 0), 1,
                  pt_flat(32'h0640_0000, 32'h0320_0000, 0, 24'h0A141E, 1, 1));
        add_probe(2, px(40, 50, 60, 0, 0), 1,
                  pt_flat(32'h0640_0000, 32'h0320_0000, 0, 24'h28323C, 1, 1));
        add_probe(2, px(9, 20, 30, 0, 0), 1,
                  pt_flat(32'h0640_0000, 32'h0320_0000, 0, 24'h09141E, 0, 1));
        add_probe(2, px(41, 50, 60, 0, 0), 1,
                  pt_flat(32'h0640_0000, 32'h0320_0000, 0, 24'h29323C, 0, 1));
        add_probe(2, px(10, 51, 30, 0, 0), 1,
                  pt_flat(32'h0640_0000, 32'h0320_0000, 0, 24'h0A331E, 0, 1));
        add_probe(2, px(10, 20, 61, 0, 0), 1,
                  pt_flat(32'h0640_0000, 32'h0320_0000, 0, 24'h0A143D, 0, 1));
        add_probe(2, px(200, 200, 200, 0, 0), 1,
                  pt_flat(32'h0640_0000, 32'h0320_0000, 0, 24'hC8C8C8, 1, 1));
        add_probe(2, px(199, 255, 255, 0, 0), 1,
                  pt_flat(32'h0640_0000, 32'h0320_0000, 0, 24'hC7FFFF, 0, 1));
        // Far corner: x drops below the signed range and saturates, y still fits.
        add_probe(2, px(0, 0, 0, 4095, 4095), 1,
                  pt_flat(32'h8000_0000, 32'h8328_0000, 0, 24'h000000, 0, 1));
        add_probe(3, px(25, 35, 45, 7, 9), 0, '0);
        add_probe(3, px(255, 200, 230, 100, 3000), 0, '0);
        add_probe(4, px(0, 0, 0, 123, 456), 1,
                  pt_flat(32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 24'h000000, 0, 1));
        add_probe(4, px(40, 50, 60, 4095, 0), 0, '0);

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        cur_set = 0;
        foreach (probes[i]) begin
            if (probes[i].cfg_set != cur_set) begin
                wait_points_drained();
                cur_set = probes[i].cfg_set;
                apply_cfg(directed_cfg[cur_set]);
            end
            send_pixel(probes[i].pix, probes[i].typed, probes[i].want);
        end

        // The first random phase runs with no idling on either side, the third starts
        // with a long output hold-off while pixels keep coming.
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            wait_points_drained();
            apply_cfg(random_cfg());
            tx_may_idle = (phase != 0);
            rx_may_idle = (phase != 0);
            if (phase == 2)
                hold_request = 1'b1;
            for (int k = 0; k < PHASE_PIXELS; k++)
                send_pixel(random_pixel(), 1'b0, '0);
        end

        wait_points_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (point_errors == 0 && floor_points_due.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
